/* sv/assert_macros.svh */
// Assertion helpers used by the top RTL file of the envelope block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at each rising clock edge while the active-low reset is released.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

/* sv/fmenv_pkg.sv */
`default_nettype none

package fmenv_pkg;

    // Width of the envelope counter derived from the counter base.
    localparam int CounterBits = 14;

    localparam logic [9:0] KeyOnAtten = 10'h280;
    localparam logic [9:0] AttenMax   = 10'h3FF;
    localparam logic [5:0] RateMax    = 6'd63;
    localparam logic [5:0] RateTop    = 6'd60;
    localparam logic [5:0] RateFast   = 6'd48;

    // Configuration register indexes.
    localparam logic [2:0] RegAttackRate  = 3'd0;
    localparam logic [2:0] RegDecay1Rate  = 3'd1;
    localparam logic [2:0] RegDecayLevel  = 3'd2;
    localparam logic [2:0] RegDecay2Rate  = 3'd3;
    localparam logic [2:0] RegCounterBase = 3'd4;
    localparam logic [2:0] RegRateOffset  = 3'd5;
    localparam logic [2:0] RegClockOnOdd  = 3'd6;
    localparam logic [2:0] RegAltRows     = 3'd7;

    typedef enum logic [1:0] {
        PhAttack = 2'd0,
        PhDecay1 = 2'd1,
        PhDecay2 = 2'd2
    } t_phase;

    typedef struct packed {
        logic [4:0]  attack_rate;
        logic [4:0]  decay1_rate;
        logic [4:0]  decay_level;
        logic [4:0]  decay2_rate;
        logic [13:0] counter_base;
        logic        rate_offset;
        logic        clock_on_odd;
        logic        alt_rows;
    } t_cfg;

    typedef struct packed {
        logic [9:0] atten;
        t_phase     phase;
        logic       silenced;
    } t_env_state;

    // Increment rows, indexed by row and by three counter bits (the low ones for fast rates).
    localparam logic [3:0] RateRows [17][8] = '{
        '{0, 1, 0, 1, 0, 1, 0, 1}, '{0, 1, 0, 1, 1, 1, 0, 1},
        '{0, 1, 1, 1, 0, 1, 1, 1}, '{0, 1, 1, 1, 1, 1, 1, 1},
        '{1, 1, 1, 1, 1, 1, 1, 1}, '{1, 2, 1, 1, 1, 2, 1, 1},
        '{1, 2, 1, 2, 1, 2, 1, 2}, '{1, 2, 2, 2, 1, 2, 2, 2},
        '{2, 2, 2, 2, 2, 2, 2, 2}, '{2, 4, 2, 2, 2, 4, 2, 2},
        '{2, 4, 2, 4, 2, 4, 2, 4}, '{2, 4, 4, 4, 2, 4, 4, 4},
        '{4, 4, 4, 4, 4, 4, 4, 4}, '{4, 8, 4, 4, 4, 8, 4, 4},
        '{4, 8, 4, 8, 4, 8, 4, 8}, '{4, 8, 8, 8, 4, 8, 8, 8},
        '{8, 8, 8, 8, 8, 8, 8, 8}
    };

    localparam logic [3:0] OtherRows [3][8] = '{
        '{1, 1, 1, 2, 1, 1, 1, 2},
        '{2, 2, 2, 4, 2, 2, 2, 4},
        '{4, 4, 4, 8, 4, 4, 4, 8}
    };

    // Effective rate: the setting doubled, zero staying zero, capped at the maximum.
    function automatic logic [5:0] rate_eff(input logic [4:0] setting);
        logic [5:0] r;
        r = {setting, 1'b0};
        return (r > RateMax) ? RateMax : r;
    endfunction

    function automatic logic [3:0] step_size(
        input logic [5:0]             rate,
        input logic [CounterBits-1:0] cnt,
        input logic                   offset,
        input logic                   alt
    );
        logic [CounterBits-1:0] c;
        logic [3:0]             sh;
        logic [4:0]             row;
        logic [3:0]             inc;
        c   = offset ? CounterBits'(cnt - 1'b1) : cnt;
        sh  = 4'(4'd11 - {2'b00, rate[5:2]});
        row = (rate >= RateTop) ? 5'd16 : 5'(rate - 6'd44);
        inc = 4'd0;
        if (rate == 6'd0) begin
            inc = 4'd0;
        end else if (rate < RateFast) begin
            // Slow rates step only when the counter's low bits below the shift are zero.
            if ((c & ~({CounterBits{1'b1}} << sh)) == '0) begin
                inc = RateRows[{3'b000, rate[1:0]}][3'(c >> sh)];
            end
        end else begin
            inc = RateRows[row][cnt[2:0]];
            if (alt) begin
                case (row) inside
                    5'd5, 5'd9, 5'd13: inc = OtherRows[2'(row[3:2] - 2'd1)][cnt[2:0]];
                    default: ;
                endcase
            end
        end
        return inc;
    endfunction

    // Logarithmic level: 16 * ((32767 * (127 - mantissa)) >> (7 + exponent)).
    function automatic logic [18:0] level_of(input logic [9:0] a);
        logic [6:0]  m;
        logic [21:0] prod;
        logic [4:0]  sh;
        m    = 7'(7'd127 - {1'b0, a[5:0]});
        prod = (22'(m) << 15) - 22'(m);
        sh   = 5'(5'd7 + {1'b0, a[9:6]});
        return 19'({22'(prod >> sh), 4'b0000});
    endfunction

endpackage

`default_nettype wire

/* sv/fmenv_step.sv */
`default_nettype none

// Next envelope state and level for one sample.
module fmenv_step (
    input  var fmenv_pkg::t_cfg       i_cfg,
    input  var fmenv_pkg::t_env_state i_state,
    input  wire logic                 i_key_on,
    input  wire logic [15:0]          i_sample_count,
    output var fmenv_pkg::t_env_state o_state,
    output wire logic [18:0]          o_level
);

    logic                              tick;
    logic [fmenv_pkg::CounterBits-1:0] cnt;
    logic [5:0]                        rate;
    logic [3:0]                        inc;
    logic [13:0]                       down_full;
    logic [9:0]                        down;
    logic [10:0]                       diff;
    logic [10:0]                       sum;
    fmenv_pkg::t_env_state             n_state;

    assign tick = i_cfg.clock_on_odd ? i_sample_count[0] : ~i_sample_count[0];
    assign cnt  = fmenv_pkg::CounterBits'(
                      fmenv_pkg::CounterBits'(i_cfg.counter_base)
                    - fmenv_pkg::CounterBits'(i_sample_count >> 1));

    always_comb begin
        unique case (i_state.phase)
            fmenv_pkg::PhAttack: rate = fmenv_pkg::rate_eff(i_cfg.attack_rate);
            fmenv_pkg::PhDecay1: rate = fmenv_pkg::rate_eff(i_cfg.decay1_rate);
            default:             rate = fmenv_pkg::rate_eff(i_cfg.decay2_rate);
        endcase
    end

    assign inc = fmenv_pkg::step_size(rate, cnt, i_cfg.rate_offset, i_cfg.alt_rows);

    // Attack moves down by ceil((a + 1) * inc / 16); decay adds the increment.
    assign down_full = 14'(({3'b000, 11'(i_state.atten) + 11'd1} * {10'd0, inc}) + 14'd15);
    assign down      = down_full[13:4];
    assign diff      = {1'b0, i_state.atten} - {1'b0, down};
    assign sum       = {1'b0, i_state.atten} + {7'd0, inc};

    always_comb begin
        n_state = i_state;
        if (i_key_on) begin
            n_state.atten    = (fmenv_pkg::rate_eff(i_cfg.attack_rate) >= fmenv_pkg::RateMax)
                             ? 10'd0 : fmenv_pkg::KeyOnAtten;
            n_state.phase    = fmenv_pkg::PhAttack;
            n_state.silenced = 1'b0;
        end else if (tick && !i_state.silenced) begin
            if (inc != 4'd0) begin
                if (i_state.phase == fmenv_pkg::PhAttack) begin
                    if (diff[10] || diff == 11'd0) begin
                        n_state.atten = 10'd0;
                        n_state.phase = fmenv_pkg::PhDecay1;
                    end else begin
                        n_state.atten = diff[9:0];
                    end
                end else if (sum[10]) begin
                    n_state.atten    = fmenv_pkg::AttenMax;
                    n_state.silenced = 1'b1;
                end else begin
                    n_state.atten = sum[9:0];
                end
            end
            // The level switch is tested on every clocked sample that began in first decay.
            if (i_state.phase == fmenv_pkg::PhDecay1 && !n_state.silenced
                    && n_state.atten[9:5] == i_cfg.decay_level) begin
                n_state.phase = fmenv_pkg::PhDecay2;
            end
        end
    end

    assign o_state = n_state;
    assign o_level = n_state.silenced ? 19'd0 : fmenv_pkg::level_of(n_state.atten);

endmodule

`default_nettype wire

/* sv/fm_envelope_attack_decay.sv */
// Channel   | Direction | Payload
// s_axis    | in        | tuser: key_on; tdata[15:0]: sample_count
// m_axis    | out       | tdata: level[18:0], attenuation[28:19], phase[30:29], silenced[31]
// i_cfg_*   | in        | write enable, 3-bit register index, 14-bit data
//
// Each word passes an input register and a result register. Once the result register can
// take it, a word moves on from the input register and its result is loaded and offered
// on m_axis from the result register. One word is taken every cycle while the output side
// keeps up. The envelope state updates in the single cycle where a word moves from the
// input register into the result register. A stall on m_axis holds the result register
// and then the input register; s_axis tready drops only when both registers are full
// and m_axis tready is low.
// Reset is synchronous and active low; it clears the valid flags and sets the envelope
// state and the configuration registers to their reset values.
`default_nettype none

module fm_envelope_attack_decay (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output wire logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // sample_count
    input  wire logic        s_axis_tuser,   // key_on
    output wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output wire logic [31:0] m_axis_tdata,   // level, attenuation, phase, silenced
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [13:0] i_cfg_data
);

`include "assert_macros.svh"

    // Configuration and envelope state.
    fmenv_pkg::t_cfg       r_cfg;
    fmenv_pkg::t_env_state r_state;
    fmenv_pkg::t_env_state n_state;
    logic [18:0]           n_level;

    // Input register stage.
    logic                  r_in_valid;
    logic                  r_key_on;
    logic [15:0]           r_sample_count;

    // Result register stage.
    logic                  r_out_valid;
    logic [18:0]           r_out_level;
    fmenv_pkg::t_env_state r_out_state;

    logic                  out_ready;
    logic                  in_accept;
    logic                  in_advance;

    // The result register can take a word when it is empty or its word leaves now.
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign in_advance    = r_in_valid && out_ready;
    assign s_axis_tready = !r_in_valid || out_ready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    fmenv_step u_step (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_key_on       (r_key_on),
        .i_sample_count (r_sample_count),
        .o_state        (n_state),
        .o_level        (n_level)
    );

    // Control state, configuration and envelope state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{atten: fmenv_pkg::KeyOnAtten, phase: fmenv_pkg::PhAttack,
                             silenced: 1'b0};
            r_cfg       <= '{attack_rate: 5'd0, decay1_rate: 5'd0, decay_level: 5'd0,
                             decay2_rate: 5'd0, counter_base: 14'd0, rate_offset: 1'b1,
                             clock_on_odd: 1'b0, alt_rows: 1'b0};
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (in_advance) begin
                r_in_valid <= 1'b0;
            end

            if (in_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fmenv_pkg::RegAttackRate:  r_cfg.attack_rate  <= i_cfg_data[4:0];
                    fmenv_pkg::RegDecay1Rate:  r_cfg.decay1_rate  <= i_cfg_data[4:0];
                    fmenv_pkg::RegDecayLevel:  r_cfg.decay_level  <= i_cfg_data[4:0];
                    fmenv_pkg::RegDecay2Rate:  r_cfg.decay2_rate  <= i_cfg_data[4:0];
                    fmenv_pkg::RegCounterBase: r_cfg.counter_base <= i_cfg_data;
                    fmenv_pkg::RegRateOffset:  r_cfg.rate_offset  <= i_cfg_data[0];
                    fmenv_pkg::RegClockOnOdd:  r_cfg.clock_on_odd <= i_cfg_data[0];
                    fmenv_pkg::RegAltRows:     r_cfg.alt_rows     <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_key_on       <= s_axis_tuser;
            r_sample_count <= s_axis_tdata;
        end
        if (in_advance) begin
            r_out_level <= n_level;
            r_out_state <= n_state;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_state.silenced, r_out_state.phase, r_out_state.atten,
                            r_out_level};

    // A silenced channel is pinned at full attenuation.
    `ASSERT_AT(a_silenced_full, i_clk, i_rst_n,
               r_state.silenced |-> r_state.atten == fmenv_pkg::AttenMax,
               "silenced channel without full attenuation")
    // Silencing happens only in decay, and key-on clears it.
    `ASSERT_NEVER(a_silenced_attack, i_clk, i_rst_n,
                  r_state.silenced && r_state.phase == fmenv_pkg::PhAttack,
                  "silenced channel in attack")
    // A key-on word reloads the envelope.
    `ASSERT_AT(a_key_on_load, i_clk, i_rst_n,
               (in_advance && r_key_on) |=> (r_state.atten == fmenv_pkg::KeyOnAtten
                   && r_state.phase == fmenv_pkg::PhAttack && !r_state.silenced),
               "key-on did not reload the envelope")
    // The pending result always mirrors the envelope state.
    `ASSERT_AT(a_result_mirrors_state, i_clk, i_rst_n,
               r_out_valid |-> r_out_state == r_state,
               "result register out of step with envelope state")

endmodule

`default_nettype wire

/* tb/env_checker.sv */
`default_nettype none

module env_checker
    import fmenv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic        i_in_key_on,
    input  wire logic [15:0] i_in_smp_count,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [31:0] i_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [13:0] i_cfg_data,
    output logic [31:0]      o_fail_count,
    output logic [31:0]      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Same bit layout as the result word, silenced in the top bit.
    typedef struct packed {
        logic       silenced;
        t_phase     phase;
        logic [9:0] atten;
        logic [18:0] level;
    } t_env_result;

    t_cfg        regs;
    logic [9:0]  atten;
    t_phase      phase;
    logic        silenced;
    t_env_result expected_words[$];
    t_env_result got;
    t_env_result want;
    int          mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] envelope mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Each row packs eight 4-bit increments, entry 0 in the lowest nibble.
    function automatic logic [31:0] row_pattern(input int row, input logic alt);
        if (alt && row == 5) return 32'h2111_2111;
        if (alt && row == 9) return 32'h4222_4222;
        if (alt && row == 13) return 32'h8444_8444;
        case (row)
            0:  return 32'h1010_1010;
            1:  return 32'h1011_1010;
            2:  return 32'h1110_1110;
            3:  return 32'h1111_1110;
            4:  return 32'h1111_1111;
            5:  return 32'h1121_1121;
            6:  return 32'h2121_2121;
            7:  return 32'h2221_2221;
            8:  return 32'h2222_2222;
            9:  return 32'h2242_2242;
            10: return 32'h4242_4242;
            11: return 32'h4442_4442;
            12: return 32'h4444_4444;
            13: return 32'h4484_4484;
            14: return 32'h8484_8484;
            15: return 32'h8884_8884;
            default: return 32'h8888_8888;
        endcase
    endfunction

    function automatic int unsigned rate_from_setting(input logic [4:0] setting);
        int unsigned r;
        r = 2 * int'(setting);
        if (setting == 5'd0) return 0;
        return (r > 63) ? 63 : r;
    endfunction

    function automatic int unsigned tick_inc(input int unsigned rate, input logic [13:0] cnt);
        logic [13:0] c;
        logic [31:0] pat;
        int unsigned sh;
        int          row;
        if (rate == 0) return 0;
        if (rate < 48) begin
            c  = regs.rate_offset ? 14'(cnt - 14'd1) : cnt;
            sh = 11 - rate / 4;
            if ((c & 14'((14'd1 << sh) - 14'd1)) != 14'd0) return 0;
            pat = row_pattern(int'(rate % 4), 1'b0);
            return int'(pat[int'((c >> sh) & 14'd7) * 4 +: 4]);
        end
        row = (rate >= 60) ? 16 : 4 + int'(rate) - 48;
        pat = row_pattern(row, regs.alt_rows);
        return int'(pat[int'(cnt[2:0]) * 4 +: 4]);
    endfunction

    function automatic logic [18:0] level_for(input logic [9:0] a);
        int unsigned m;
        int unsigned k;
        m = 127 - int'(a[5:0]);
        k = int'(a[9:6]);
        return 19'(16 * ((32767 * m) >> (7 + k)));
    endfunction

    task automatic predict_word(input logic key_on, input logic [15:0] smp_count,
                                output t_env_result r);
        logic        tick;
        logic [13:0] cnt;
        logic        in_d1;
        int unsigned rate;
        int unsigned inc;
        int          down;
        int          trial;
        if (key_on) begin
            atten    = (rate_from_setting(regs.attack_rate) >= 63) ? 10'h000 : 10'h280;
            phase    = PhAttack;
            silenced = 1'b0;
        end else begin
            tick = regs.clock_on_odd ? smp_count[0] : !smp_count[0];
            if (tick && !silenced) begin
                cnt   = 14'(regs.counter_base - smp_count[15:1]);
                in_d1 = (phase == PhDecay1);
                if (phase == PhAttack) rate = rate_from_setting(regs.attack_rate);
                else if (phase == PhDecay1) rate = rate_from_setting(regs.decay1_rate);
                else rate = rate_from_setting(regs.decay2_rate);
                inc = tick_inc(rate, cnt);
                if (inc != 0) begin
                    if (phase == PhAttack) begin
                        down  = ((int'(atten) + 1) * int'(inc) + 15) >> 4;
                        trial = int'(atten) - down;
                        if (trial <= 0) begin
                            atten = 10'h000;
                            phase = PhDecay1;
                        end else begin
                            atten = 10'(trial);
                        end
                    end else begin
                        trial = int'(atten) + int'(inc);
                        if (trial > 1023) begin
                            atten    = 10'h3FF;
                            silenced = 1'b1;
                        end else begin
                            atten = 10'(trial);
                        end
                    end
                end
                // The level test runs on every clocked sample that started in first decay.
                if (in_d1 && !silenced && atten[9:5] == regs.decay_level) phase = PhDecay2;
            end
        end
        r.level    = silenced ? 19'd0 : level_for(atten);
        r.atten    = atten;
        r.phase    = phase;
        r.silenced = silenced;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs              = '0;
            regs.rate_offset  = 1'b1;
            atten             = 10'h280;
            phase             = PhAttack;
            silenced          = 1'b0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    RegAttackRate:  regs.attack_rate  = i_cfg_data[4:0];
                    RegDecay1Rate:  regs.decay1_rate  = i_cfg_data[4:0];
                    RegDecayLevel:  regs.decay_level  = i_cfg_data[4:0];
                    RegDecay2Rate:  regs.decay2_rate  = i_cfg_data[4:0];
                    RegCounterBase: regs.counter_base = i_cfg_data;
                    RegRateOffset:  regs.rate_offset  = i_cfg_data[0];
                    RegClockOnOdd:  regs.clock_on_odd = i_cfg_data[0];
                    RegAltRows:     regs.alt_rows     = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = t_env_result'(i_out_data);
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("result word %h with none outstanding", i_out_data));
                end else begin
                    want = expected_words.pop_front();
                    if (got.level != want.level)
                        report_mismatch($sformatf("level got %0d expected %0d",
                                                  got.level, want.level));
                    if (got.atten != want.atten)
                        report_mismatch($sformatf("attenuation got %0d expected %0d",
                                                  got.atten, want.atten));
                    if (got.phase != want.phase)
                        report_mismatch($sformatf("phase got %0d expected %0d",
                                                  got.phase, want.phase));
                    if (got.silenced != want.silenced)
                        report_mismatch($sformatf("silenced got %0d expected %0d",
                                                  got.silenced, want.silenced));
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_word(i_in_key_on, i_in_smp_count, want);
                expected_words = {expected_words, want};
            end
        end
        o_pending    <= 32'(expected_words.size());
        o_fail_count <= 32'(mismatches);
    end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

// Top of the envelope regression. It writes the configuration, drives sample words into
// the block, shapes the traffic on both streams and gives the verdict; all prediction and
// comparison happens in the checker instantiated beside the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fmenv_pkg::*;

    // Generous ceiling on the length of a correct run.
    localparam int CycleLimit = 400_000;

    // Patterns the result side cycles through.
    localparam int ReadyAlways = 0;
    localparam int ReadyCoin   = 1;
    localparam int ReadySparse = 2;

    // Words of random traffic per configuration phase.
    localparam int PhaseWords  = 230;
    localparam int PhaseCount  = 8;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        in_key_on   = 1'b0;    // tuser: key_on
    logic [15:0] in_smp      = 16'h0;   // tdata[15:0]: sample_count
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [31:0] out_data;              // level, attenuation, phase, silenced (low to high)
    logic        cfg_we      = 1'b0;
    logic [2:0]  cfg_index   = RegAttackRate;
    logic [13:0] cfg_data    = 14'h0;
    logic [31:0] fail_count;
    logic [31:0] pending;

    int burst_left   = 1;
    int ready_mode   = ReadyAlways;
    int window_left  = 0;
    int cycle_count  = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    fm_envelope_attack_decay u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_smp),
        .s_axis_tuser  (in_key_on),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    env_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_key_on    (in_key_on),
        .i_in_smp_count (in_smp),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // The result side picks a pattern for a window of cycles: always ready, a coin
    // toss per cycle, or mostly stalled. This moves the back-pressure across every
    // stage of the envelope sequence.
    always @(posedge clk) begin
        if (window_left == 0) begin
            ready_mode  <= $urandom_range(ReadyAlways, ReadySparse);
            window_left <= $urandom_range(16, 128);
        end else begin
            window_left <= window_left - 1;
        end
        case (ready_mode)
            ReadyAlways: out_ready <= 1'b1;
            ReadyCoin:   out_ready <= 1'($urandom_range(0, 1));
            default:     out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("fm_envelope_attack_decay regression: fail");
            $finish;
        end
    end

    // Offers one sample word and returns in the time step of the edge that takes it.
    // Words go out in bursts; when a burst ends the valid line drops for a random gap,
    // and a gap of zero keeps the stream dense across the burst boundary.
    task automatic send_word(input logic key_on, input logic [15:0] smp);
        int gap;
        in_valid  <= 1'b1;
        in_key_on <= key_on;
        in_smp    <= smp;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stops the sender until every outstanding result has been seen. The pending count
    // is registered, so it lags the queue in the checker; the trailing cycles
    // cover the two-stage pipeline before the registers are touched again.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [13:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Writes every register back to back. Bits above a register's width carry random
    // junk, which the block is expected to drop.
    task automatic apply_settings(input t_cfg cfg);
        put_reg(RegAttackRate,  {9'($urandom), cfg.attack_rate});
        put_reg(RegDecay1Rate,  {9'($urandom), cfg.decay1_rate});
        put_reg(RegDecayLevel,  {9'($urandom), cfg.decay_level});
        put_reg(RegDecay2Rate,  {9'($urandom), cfg.decay2_rate});
        put_reg(RegCounterBase, cfg.counter_base);
        put_reg(RegRateOffset,  {13'($urandom), cfg.rate_offset});
        put_reg(RegClockOnOdd,  {13'($urandom), cfg.clock_on_odd});
        put_reg(RegAltRows,     {13'($urandom), cfg.alt_rows});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Rates lean toward the fast end so that envelopes actually move, finish the attack
    // and run into overflow within a few hundred samples.
    function automatic logic [4:0] pick_rate();
        if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
        return 5'($urandom_range(22, 31));
    endfunction

    function automatic t_cfg random_settings();
        t_cfg cfg;
        cfg.attack_rate  = pick_rate();
        cfg.decay1_rate  = pick_rate();
        cfg.decay_level  = 5'($urandom_range(0, 31));
        cfg.decay2_rate  = pick_rate();
        cfg.counter_base = 14'($urandom);
        cfg.rate_offset  = 1'($urandom_range(0, 1));
        cfg.clock_on_odd = 1'($urandom_range(0, 1));
        cfg.alt_rows     = 1'($urandom_range(0, 1));
        return cfg;
    endfunction

    // Most traffic is a key-on followed by a run of down-counting samples, the way a
    // real note plays out; some runs step by two so one parity never ticks. About one pick
    // in ten is a single noise word instead of a run: random key flag and random counter value.
    task automatic run_phase(input int budget);
        int          sent;
        int          len;
        int          stride;
        int          k;
        logic [15:0] smp;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(1'($urandom_range(0, 1)), 16'($urandom));
                sent++;
            end else begin
                smp    = 16'($urandom);
                stride = ($urandom_range(0, 7) == 0) ? 2 : 1;
                len    = $urandom_range(8, 320);
                send_word(1'b1, smp);
                sent++;
                for (k = 0; k < len && sent < budget; k++) begin
                    smp = 16'(smp - stride);
                    send_word(1'b0, smp);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        t_cfg cfg;
        int   p;
        int   s;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: all rates zero, so nothing steps; counter values at both ends
        // and an alternating bit pattern.
        send_word(1'b1, 16'h0000);
        send_word(1'b0, 16'hFFFF);
        send_word(1'b0, 16'h5555);
        wait_for_results();

        // Fastest rates with a decay level of zero: the attack runs all the way to zero
        // in nine ticks, the first decay tick then lands in the lowest level band and
        // the phase switches to second decay.
        cfg = '{attack_rate: 5'd31, decay1_rate: 5'd31, decay_level: 5'd0,
                decay2_rate: 5'd31, counter_base: 14'h0000, rate_offset: 1'b0,
                clock_on_odd: 1'b0, alt_rows: 1'b1};
        apply_settings(cfg);
        send_word(1'b1, 16'hAAAA);
        for (s = 19; s >= 0; s--) send_word(1'b0, 16'(s));
        wait_for_results();

        // Random traffic over a series of settings. Every phase boundary is a full drain
        // of the pipeline, so the sender sits idle until all results are back.
        for (p = 0; p < PhaseCount; p++) begin
            cfg = random_settings();
            case (p)
                0: begin
                    // All rates at their maximum: long runs end in overflow and silence.
                    cfg.attack_rate = 5'd31;
                    cfg.decay1_rate = 5'd31;
                    cfg.decay2_rate = 5'd31;
                end
                1: begin
                    // Rates on both sides of the fast-row boundary and at the top row,
                    // with the counter base at its maximum.
                    cfg.attack_rate  = 5'd23;
                    cfg.decay1_rate  = 5'd24;
                    cfg.decay_level  = 5'd31;
                    cfg.decay2_rate  = 5'd30;
                    cfg.counter_base = 14'h3FFF;
                    cfg.rate_offset  = 1'b1;
                    cfg.clock_on_odd = 1'b1;
                    cfg.alt_rows     = 1'b0;
                end
                2: begin
                    // Zero base with the offset applied, so the slow-rate counter wraps.
                    cfg.counter_base = 14'h0000;
                    cfg.rate_offset  = 1'b1;
                end
                default: ;
            endcase
            apply_settings(cfg);
            run_phase(PhaseWords);
            wait_for_results();
        end

        repeat (4) @(posedge clk);
        if (fail_count == 0) begin
            $display("fm_envelope_attack_decay regression: pass");
        end else begin
            $display("fm_envelope_attack_decay regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* fm_envelope_attack_decay.f */
+incdir+sv
sv/fmenv_pkg.sv
sv/fmenv_step.sv
sv/fm_envelope_attack_decay.sv
tb/env_checker.sv
tb/testbench.sv
